/* rtl/cprt_pkg.sv */
package cprt_pkg;

    localparam int NODE_COUNT = 2;
    localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PENDING = 2'd1,
        PH_ACKED   = 2'd2,
        PH_FAILED  = 2'd3
    } t_phase;

    localparam logic [2:0] EV_SEND     = 3'd0;
    localparam logic [2:0] EV_QUEUED   = 3'd1;
    localparam logic [2:0] EV_ACKED    = 3'd2;
    localparam logic [2:0] EV_RESTART  = 3'd3;
    localparam logic [2:0] EV_NOT_APPL = 3'd4;
    localparam logic [2:0] EV_NO_ACK   = 3'd5;
    localparam logic [2:0] EV_SEEN     = 3'd6;
    localparam logic [2:0] EV_NEVER    = 3'd7;

    localparam logic [1:0] FN_PACKET = 2'd0;
    localparam logic [1:0] FN_QUEUE  = 2'd1;
    localparam logic [1:0] FN_STATUS = 2'd2;

    localparam logic [2:0] PT_WAKE = 3'd0;
    localparam logic [2:0] PT_ACK  = 3'd4;

    localparam logic [2:0] CFG_ATTEMPT = 3'd0;
    localparam logic [2:0] CFG_GRACE   = 3'd1;
    localparam logic [2:0] CFG_SLEEP   = 3'd2;
    localparam logic [2:0] CFG_WAKE    = 3'd3;
    localparam logic [2:0] CFG_MEASURE = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT2,
        ST_STATUS
    } t_state;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic [1:0]        func;
        logic [NODE_W-1:0] node;
        logic [2:0]        ptype;
        logic              ack_ok;
        logic [15:0]       rev;
        logic [31:0]       wakes;
        logic [15:0]       slp;
        logic [15:0]       wk;
        logic [7:0]        meas;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  ev;
        logic [7:0]  node;
        logic [1:0]  phase;
        logic [15:0] rev;
        logic [15:0] slp;
        logic [15:0] wk;
        logic [7:0]  meas;
        logic [3:0]  att;
        logic        last;
    } t_res;

endpackage

/* rtl/config_push_retry_tracker.sv */
// Flow: an item is registered in the front queue, then in the back end's
// command register, and its first result is then registered; a second result,
// or each further status beat, follows once the previous one is taken. The back
// end takes no new item until it is through with the last, as it does a single
// node-entry read-modify-write; a status report gives one beat per node.
// Reset: synchronous, active low; it clears every node entry and loads the
// register defaults.
module config_push_retry_tracker import cprt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_node_id,
    input  logic [2:0]  i_packet_type,
    input  logic        i_ack_ok,
    input  logic [15:0] i_reported_revision,
    input  logic [31:0] i_wake_count,
    input  logic [15:0] i_sleep_seconds,
    input  logic [15:0] i_wake_seconds,
    input  logic [7:0]  i_measure_count,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_out_node,
    output logic [1:0]  o_push_state,
    output logic [15:0] o_out_revision,
    output logic [15:0] o_out_sleep,
    output logic [15:0] o_out_wake,
    output logic [7:0]  o_out_measure,
    output logic [3:0]  o_out_attempts,
    output logic        o_last
);

    // The front filters and queues commands; the back owns the node table.
    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;
    t_res res;

    cprt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_func, .i_node_id, .i_packet_type,
        .i_ack_ok, .i_reported_revision, .i_wake_count, .i_sleep_seconds,
        .i_wake_seconds, .i_measure_count,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    cprt_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid, .i_ready, .o_res(res)
    );

    assign o_event_res    = res.ev;
    assign o_out_node     = res.node;
    assign o_push_state   = res.phase;
    assign o_out_revision = res.rev;
    assign o_out_sleep    = res.slp;
    assign o_out_wake     = res.wk;
    assign o_out_measure  = res.meas;
    assign o_out_attempts = res.att;
    assign o_last         = res.last;

endmodule

/* rtl/cprt_front.sv */
module cprt_front import cprt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_node_id,
    input  logic [2:0]  i_packet_type,
    input  logic        i_ack_ok,
    input  logic [15:0] i_reported_revision,
    input  logic [31:0] i_wake_count,
    input  logic [15:0] i_sleep_seconds,
    input  logic [15:0] i_wake_seconds,
    input  logic [7:0]  i_measure_count,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [1:0]        r_cnt;
    logic              r_wp;
    logic              r_rp;
    logic              keep;
    logic              push;
    logic              pop;
    t_cmd              cmd;

    // Items that can give no result are dropped here.
    always_comb begin
        keep = 1'b0;
        if (i_func == FN_STATUS) begin
            keep = 1'b1;
        end else if (i_func == FN_PACKET || i_func == FN_QUEUE) begin
            keep = (i_node_id != 8'd0) && ({24'd0, i_node_id} <= 32'(NODE_COUNT));
        end
        cmd.func   = i_func;
        cmd.node   = NODE_W'(i_node_id - 8'd1);
        cmd.ptype  = i_packet_type;
        cmd.ack_ok = i_ack_ok;
        cmd.rev    = i_reported_revision;
        cmd.wakes  = i_wake_count;
        cmd.slp    = i_sleep_seconds;
        cmd.wk     = i_wake_seconds;
        cmd.meas   = i_measure_count;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1)) else $error("count slip");

endmodule

/* rtl/cprt_back.sv */
module cprt_back import cprt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res        o_res
);

    logic [3:0]  r_lim, r_grace;
    logic [15:0] r_smax, r_wmax;
    logic [7:0]  r_mmax;

    t_phase      r_ph   [NODE_COUNT];
    logic [3:0]  r_att  [NODE_COUNT];
    logic [15:0] r_wrev [NODE_COUNT];
    logic [15:0] r_wslp [NODE_COUNT];
    logic [15:0] r_wwk  [NODE_COUNT];
    logic [7:0]  r_wms  [NODE_COUNT];
    logic        r_seen [NODE_COUNT];
    logic [31:0] r_pw   [NODE_COUNT];
    logic        r_pwv  [NODE_COUNT];
    logic [31:0] r_aw   [NODE_COUNT];
    logic [15:0] r_mrr  [NODE_COUNT];

    t_state      r_st, n_st;
    t_cmd        r_cmd;
    logic [NODE_W-1:0] r_sn, n_sn;
    logic [2:0]  r_ev2, n_ev2;
    logic        r_ov, n_ov;
    t_res        r_res, n_res;

    logic        n_wr;
    t_phase      n_ph;
    logic [3:0]  n_att;
    logic [15:0] n_wrev, n_wslp, n_wwk, n_mrr;
    logic [7:0]  n_wms;
    logic [31:0] n_pw, n_aw;
    logic        n_seen, n_pwv;

    logic [NODE_W-1:0] nd;
    logic [15:0] base, nrev;
    logic        restarted, notappl, bad;
    logic [32:0] grace_sum;
    logic [3:0]  att_inc;
    logic        out_free;

    assign out_free    = !r_ov || i_ready;
    assign o_cmd_ready = (r_st == ST_IDLE);
    assign o_valid     = r_ov;
    assign o_res       = r_res;
    assign nd          = r_cmd.node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= 4'd4; r_grace <= 4'd2;
            r_smax <= 16'hFFFF; r_wmax <= 16'hFFFF; r_mmax <= 8'hFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATTEMPT: r_lim   <= i_cfg_data[3:0];
                CFG_GRACE:   r_grace <= i_cfg_data[3:0];
                CFG_SLEEP:   r_smax  <= i_cfg_data;
                CFG_WAKE:    r_wmax  <= i_cfg_data;
                CFG_MEASURE: r_mmax  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    function automatic t_res mk(logic [2:0] ev, logic [NODE_W-1:0] n, t_phase ph,
                                logic [15:0] rv, logic [15:0] s, logic [15:0] w,
                                logic [7:0] m, logic [3:0] a, logic l);
        t_res r;
        r.ev = ev; r.node = 8'(n) + 8'd1; r.phase = ph; r.rev = rv;
        r.slp = s; r.wk = w; r.meas = m; r.att = a; r.last = l;
        return r;
    endfunction

    always_comb begin
        n_st = r_st; n_sn = r_sn; n_ev2 = r_ev2; n_ov = r_ov; n_res = r_res;
        n_wr = 1'b0;
        n_ph = r_ph[nd]; n_att = r_att[nd]; n_wrev = r_wrev[nd];
        n_wslp = r_wslp[nd]; n_wwk = r_wwk[nd]; n_wms = r_wms[nd];
        n_seen = r_seen[nd]; n_pw = r_pw[nd]; n_pwv = r_pwv[nd];
        n_aw = r_aw[nd]; n_mrr = r_mrr[nd];
        base = (r_mrr[nd] > r_wrev[nd]) ? r_mrr[nd] : r_wrev[nd];
        nrev = base + 16'd1;
        bad = (nrev == 16'd0) || (r_cmd.slp == 16'd0) || (r_cmd.slp > r_smax) ||
              (r_cmd.wk == 16'd0) || (r_cmd.wk > r_wmax) ||
              (r_cmd.meas == 8'd0) || (r_cmd.meas > r_mmax);
        restarted = r_pwv[nd] && (r_cmd.wakes < r_pw[nd]);
        grace_sum = {1'b0, r_aw[nd]} + 33'(r_grace);
        notappl = (r_ph[nd] == PH_ACKED) && (r_cmd.rev < r_wrev[nd]) &&
                  ({1'b0, r_cmd.wakes} >= grace_sum);
        att_inc = 4'd0;
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_st)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_st = (i_cmd.func == FN_STATUS) ? ST_STATUS : ST_EXEC;
                    n_sn = '0;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_st = ST_IDLE;
                    if (r_cmd.func == FN_QUEUE) begin
                        if (!bad) begin
                            n_wr = 1'b1;
                            n_wrev = nrev; n_wslp = r_cmd.slp; n_wwk = r_cmd.wk;
                            n_wms = r_cmd.meas; n_ph = PH_PENDING; n_att = 4'd0;
                            n_ov = 1'b1;
                            n_res = mk(EV_QUEUED, nd, n_ph, n_wrev, n_wslp, n_wwk,
                                       n_wms, n_att, 1'b1);
                        end
                    end else if (r_cmd.ptype == PT_ACK) begin
                        n_wr = 1'b1;
                        n_seen = 1'b1;
                        if (r_ph[nd] == PH_PENDING && r_cmd.ack_ok) begin
                            n_ph = PH_ACKED; n_aw = r_cmd.wakes;
                            n_ov = 1'b1;
                            n_res = mk(EV_ACKED, nd, n_ph, n_wrev, n_wslp, n_wwk,
                                       n_wms, n_att, 1'b1);
                        end
                    end else begin
                        n_wr = 1'b1;
                        n_seen = 1'b1; n_pw = r_cmd.wakes; n_pwv = 1'b1;
                        if (r_cmd.rev > r_mrr[nd]) begin
                            n_mrr = r_cmd.rev;
                        end
                        if (r_wrev[nd] != 16'd0 && (restarted || notappl)) begin
                            n_ph = PH_PENDING; n_att = 4'd0;
                            n_ov = 1'b1;
                            n_res = mk(restarted ? EV_RESTART : EV_NOT_APPL, nd, n_ph,
                                       n_wrev, n_wslp, n_wwk, n_wms, n_att, 1'b1);
                        end
                        if (r_cmd.ptype == PT_WAKE && n_ph == PH_PENDING) begin
                            att_inc = (n_att < 4'd15) ? n_att + 4'd1 : n_att;
                            n_att = att_inc;
                            n_ev2 = EV_SEND;
                            if (att_inc >= r_lim) begin
                                n_ph = PH_FAILED;
                                n_ev2 = EV_NO_ACK;
                            end
                            if (n_ov && !(r_ov && i_ready) && r_ov) begin
                                n_ov = 1'b1;
                            end
                            if (n_res.ev == EV_RESTART || n_res.ev == EV_NOT_APPL) begin
                                if (r_wrev[nd] != 16'd0 && (restarted || notappl)) begin
                                    n_res.last = 1'b0;
                                    n_st = ST_EMIT2;
                                end
                            end
                            if (n_st != ST_EMIT2) begin
                                n_ov = 1'b1;
                                n_res = mk(n_ev2, nd, n_ph, n_wrev, n_wslp, n_wwk,
                                           n_wms, n_att, 1'b1);
                            end
                        end
                    end
                end
            end
            ST_EMIT2: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_res = mk(r_ev2, nd, r_ph[nd], r_wrev[nd], r_wslp[nd], r_wwk[nd],
                               r_wms[nd], r_att[nd], 1'b1);
                    n_st = ST_IDLE;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_res = mk(r_seen[r_sn] ? EV_SEEN : EV_NEVER, r_sn, r_ph[r_sn],
                               r_wrev[r_sn], r_wslp[r_sn], r_wwk[r_sn], r_wms[r_sn],
                               r_att[r_sn], 32'(r_sn) == NODE_COUNT - 1);
                    if (32'(r_sn) == NODE_COUNT - 1) begin
                        n_st = ST_IDLE;
                    end else begin
                        n_sn = r_sn + NODE_W'(1);
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
            r_sn <= '0;
            for (int i = 0; i < NODE_COUNT; i++) begin
                r_ph[i] <= PH_IDLE; r_att[i] <= '0; r_wrev[i] <= '0;
                r_wslp[i] <= '0; r_wwk[i] <= '0; r_wms[i] <= '0;
                r_seen[i] <= 1'b0; r_pw[i] <= '0; r_pwv[i] <= 1'b0;
                r_aw[i] <= '0; r_mrr[i] <= '0;
            end
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
            r_sn <= n_sn;
            if (n_wr) begin
                r_ph[nd] <= n_ph; r_att[nd] <= n_att; r_wrev[nd] <= n_wrev;
                r_wslp[nd] <= n_wslp; r_wwk[nd] <= n_wwk; r_wms[nd] <= n_wms;
                r_seen[nd] <= n_seen; r_pw[nd] <= n_pw; r_pwv[nd] <= n_pwv;
                r_aw[nd] <= n_aw; r_mrr[nd] <= n_mrr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_ev2 <= n_ev2;
        if (i_cmd_valid && o_cmd_ready) begin
            r_cmd <= i_cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> r_ov && $stable(r_res)) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EMIT2) |-> r_ov && !r_res.last) else $error("pair order lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EXEC) |-> !o_cmd_ready) else $error("second command taken");

endmodule
